// ===== sv/rcs_pkg.sv =====
package rcs_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 11;
	localparam int SIZE_W     = 12;
	localparam int CNT_W      = 22;
	localparam int SUM_W      = 30;
	localparam int PCT_W      = 15;
	localparam int MEAN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Frame size that the rectangle is clipped to.
	localparam int MAX_COLS = 2048;
	localparam int MAX_ROWS = 2048;

	// Dividend is either count * 25600 (37 bits) or sum * 256 (38 bits).
	localparam int DIVIDEND_W = SUM_W + 8;
	localparam int PROD_W     = CNT_W + PCT_W;

	localparam logic [PCT_W-1:0]  PCT_SCALE = 15'd25600;
	localparam logic [MEAN_W-1:0] PCT_MAX   = 16'd25600;
	localparam logic [MEAN_W-1:0] MEAN_MAX  = 16'd65280;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH_L   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH_A   = 3'd5;

	localparam logic [PIX_W-1:0] THRESH_L_RST = 8'd150;
	localparam logic [PIX_W-1:0] THRESH_A_RST = 8'd155;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_l;
		logic [PIX_W-1:0]   pixel_a;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               end_of_frame;
	} rcs_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]  roi_max_l;
		logic [PIX_W-1:0]  roi_min_l;
		logic [PCT_W-1:0]  roi_pct_l;
		logic [PIX_W-1:0]  roi_max_a;
		logic [PIX_W-1:0]  roi_min_a;
		logic [PCT_W-1:0]  roi_pct_a;
		logic [MEAN_W-1:0] roi_mean_l;
		logic [MEAN_W-1:0] roi_mean_a;
		logic [MEAN_W-1:0] frame_mean_l;
		logic [MEAN_W-1:0] frame_mean_a;
		logic              roi_empty;
	} rcs_out_t;

	typedef struct packed {
		logic [COORD_W-1:0] roi_left;
		logic [COORD_W-1:0] roi_top;
		logic [SIZE_W-1:0]  roi_width;
		logic [SIZE_W-1:0]  roi_height;
		logic [PIX_W-1:0]   thresh_l;
		logic [PIX_W-1:0]   thresh_a;
	} rcs_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] min_l;
		logic [PIX_W-1:0] max_l;
		logic [PIX_W-1:0] min_a;
		logic [PIX_W-1:0] max_a;
		logic [CNT_W-1:0] above_l;
		logic [CNT_W-1:0] above_a;
		logic [CNT_W-1:0] roi_cnt;
		logic [SUM_W-1:0] roi_sum_l;
		logic [SUM_W-1:0] roi_sum_a;
		logic [CNT_W-1:0] frame_cnt;
		logic [SUM_W-1:0] frame_sum_l;
		logic [SUM_W-1:0] frame_sum_a;
	} rcs_stats_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [CNT_W-1:0]      divisor;
	} rcs_div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} rcs_div_rsp_t;

endpackage

// ===== sv/roi_color_statistics_unit.sv =====
// A pixel without the end-of-frame mark is folded into the registered statistics, and while
// the block is idle the next pixel may follow in the next cycle.
// A pixel with the end-of-frame mark starts six divisions, run one after another on one
// shared radix-2 divider; the input stalls until the result item is handed to the output
// register, which waits while that register still holds an earlier item.
// Reset (arst_n low) clears all statistics, loads the register defaults and empties the output.
module roi_color_statistics_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  rcs_pkg::rcs_in_t                      pix,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output rcs_pkg::rcs_out_t                     res,
	input  logic                                  cfg_we,
	input  logic [rcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// Sequencer states. IDLE takes pixels; DIV runs the divisions one after another;
	// DONE waits for the output register to be free and then hands over the item.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Division jobs in the order they are run.
	typedef enum logic [2:0] {
		JOB_PCT_L   = 3'd0,
		JOB_PCT_A   = 3'd1,
		JOB_MEAN_L  = 3'd2,
		JOB_MEAN_A  = 3'd3,
		JOB_FRAME_L = 3'd4,
		JOB_FRAME_A = 3'd5
	} job_t;

	state_t                         state_q;
	job_t                           job_q;
	logic                           start_q;
	rcs_pkg::rcs_cfg_t              cfg_q;
	rcs_pkg::rcs_stats_t            stats;
	rcs_pkg::rcs_div_req_t          div_req;
	rcs_pkg::rcs_div_rsp_t          div_rsp;
	rcs_pkg::rcs_out_t              res_q;
	logic                           res_valid_q;
	logic [rcs_pkg::PCT_W-1:0]      pct_l_q;
	logic [rcs_pkg::PCT_W-1:0]      pct_a_q;
	logic [rcs_pkg::MEAN_W-1:0]     mean_l_q;
	logic [rcs_pkg::MEAN_W-1:0]     mean_a_q;
	logic [rcs_pkg::MEAN_W-1:0]     fmean_l_q;
	logic [rcs_pkg::MEAN_W-1:0]     fmean_a_q;
	logic                           pix_acc;
	logic                           out_free;
	logic                           hand_over;
	logic [rcs_pkg::CNT_W-1:0]      above_sel;
	logic [rcs_pkg::PROD_W-1:0]     pct_prod;
	logic [rcs_pkg::DIVIDEND_W-1:0] dividend;
	logic [rcs_pkg::CNT_W-1:0]      divisor;
	logic [rcs_pkg::MEAN_W-1:0]     limit;
	logic [rcs_pkg::MEAN_W-1:0]     q_clamp;
	logic                           roi_empty;

	assign pix_stall = (state_q != ST_IDLE);
	assign pix_acc   = pix_valid && (state_q == ST_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign hand_over = (state_q == ST_DONE) && out_free;
	assign roi_empty = (stats.roi_cnt == '0);

	// Configuration registers. The user must write only while the block is idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_left   <= '0;
			cfg_q.roi_top    <= '0;
			cfg_q.roi_width  <= rcs_pkg::SIZE_W'(1);
			cfg_q.roi_height <= rcs_pkg::SIZE_W'(1);
			cfg_q.thresh_l   <= rcs_pkg::THRESH_L_RST;
			cfg_q.thresh_a   <= rcs_pkg::THRESH_A_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcs_pkg::CFG_ROI_LEFT:   cfg_q.roi_left   <= cfg_data[rcs_pkg::COORD_W-1:0];
				rcs_pkg::CFG_ROI_TOP:    cfg_q.roi_top    <= cfg_data[rcs_pkg::COORD_W-1:0];
				rcs_pkg::CFG_ROI_WIDTH:  cfg_q.roi_width  <= cfg_data;
				rcs_pkg::CFG_ROI_HEIGHT: cfg_q.roi_height <= cfg_data;
				rcs_pkg::CFG_THRESH_L:   cfg_q.thresh_l   <= cfg_data[rcs_pkg::PIX_W-1:0];
				rcs_pkg::CFG_THRESH_A:   cfg_q.thresh_a   <= cfg_data[rcs_pkg::PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The statistics are cleared in the same cycle the finished item moves to the output.
	rcs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pix    (pix),
		.acc_en (pix_acc),
		.clear  (hand_over),
		.stats  (stats)
	);

	// Operand selection for the current job. A percentage scales the count by 25600,
	// a mean scales the sum by 256. The divider registers both at its start.
	assign above_sel = (job_q == JOB_PCT_L) ? stats.above_l : stats.above_a;
	assign pct_prod  = rcs_pkg::PROD_W'(above_sel) * rcs_pkg::PROD_W'(rcs_pkg::PCT_SCALE);

	always_comb begin
		dividend = '0;
		divisor  = stats.roi_cnt;
		unique case (job_q)
			JOB_PCT_L, JOB_PCT_A: dividend = rcs_pkg::DIVIDEND_W'(pct_prod);
			JOB_MEAN_L:           dividend = {stats.roi_sum_l, 8'd0};
			JOB_MEAN_A:           dividend = {stats.roi_sum_a, 8'd0};
			JOB_FRAME_L: begin
				dividend = {stats.frame_sum_l, 8'd0};
				divisor  = stats.frame_cnt;
			end
			JOB_FRAME_A: begin
				dividend = {stats.frame_sum_a, 8'd0};
				divisor  = stats.frame_cnt;
			end
			default: begin
			end
		endcase
	end

	assign div_req.start    = start_q;
	assign div_req.dividend = dividend;
	assign div_req.divisor  = divisor;

	rcs_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Clamp the quotient to the field's range. A zero rectangle count makes the
	// divider return all ones; those fields are forced to zero at hand-over.
	assign limit   = ((job_q == JOB_PCT_L) || (job_q == JOB_PCT_A)) ?
		rcs_pkg::PCT_MAX : rcs_pkg::MEAN_MAX;
	assign q_clamp = (div_rsp.quotient > rcs_pkg::DIVIDEND_W'(limit)) ?
		limit : div_rsp.quotient[rcs_pkg::MEAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_PCT_L;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc && pix.end_of_frame) begin
						state_q <= ST_DIV;
						job_q   <= JOB_PCT_L;
						start_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (job_q == JOB_FRAME_A) begin
							state_q <= ST_DONE;
						end else begin
							job_q   <= job_t'(job_q + 3'd1);
							start_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Quotient holding registers, one per division job.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_rsp.done) begin
			unique case (job_q)
				JOB_PCT_L:   pct_l_q   <= q_clamp[rcs_pkg::PCT_W-1:0];
				JOB_PCT_A:   pct_a_q   <= q_clamp[rcs_pkg::PCT_W-1:0];
				JOB_MEAN_L:  mean_l_q  <= q_clamp;
				JOB_MEAN_A:  mean_a_q  <= q_clamp;
				JOB_FRAME_L: fmean_l_q <= q_clamp;
				JOB_FRAME_A: fmean_a_q <= q_clamp;
				default: begin
				end
			endcase
		end
	end

	// Output register. It lets the next frame's pixels in while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (hand_over) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hand_over) begin
			res_q.roi_max_l    <= roi_empty ? '0 : stats.max_l;
			res_q.roi_min_l    <= roi_empty ? '0 : stats.min_l;
			res_q.roi_pct_l    <= roi_empty ? '0 : pct_l_q;
			res_q.roi_max_a    <= roi_empty ? '0 : stats.max_a;
			res_q.roi_min_a    <= roi_empty ? '0 : stats.min_a;
			res_q.roi_pct_a    <= roi_empty ? '0 : pct_a_q;
			res_q.roi_mean_l   <= roi_empty ? '0 : mean_l_q;
			res_q.roi_mean_a   <= roi_empty ? '0 : mean_a_q;
			res_q.frame_mean_l <= fmean_l_q;
			res_q.frame_mean_a <= fmean_a_q;
			res_q.roi_empty    <= roi_empty;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/rcs_accum.sv =====
module rcs_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  rcs_pkg::rcs_cfg_t  cfg,
	input  rcs_pkg::rcs_in_t   pix,
	input  logic               acc_en,
	input  logic               clear,
	output rcs_pkg::rcs_stats_t stats
);

	localparam int END_W = rcs_pkg::SIZE_W + 1;

	rcs_pkg::rcs_stats_t stats_q;
	logic [END_W-1:0]    col_end;
	logic [END_W-1:0]    row_end;
	logic                in_roi;

	// Cleared statistics: the minima start at full scale, everything else at zero.
	function automatic rcs_pkg::rcs_stats_t stats_clr();
		rcs_pkg::rcs_stats_t s;
		s       = '0;
		s.min_l = '1;
		s.min_a = '1;
		return s;
	endfunction

	// Saturating increment of a count.
	function automatic logic [rcs_pkg::CNT_W-1:0] cnt_inc(
		input logic [rcs_pkg::CNT_W-1:0] v
	);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Saturating add of one pixel value to a sum.
	function automatic logic [rcs_pkg::SUM_W-1:0] sum_add(
		input logic [rcs_pkg::SUM_W-1:0] v,
		input logic [rcs_pkg::PIX_W-1:0] p
	);
		logic [rcs_pkg::SUM_W:0] s;
		s = {1'b0, v} + (rcs_pkg::SUM_W + 1)'(p);
		return s[rcs_pkg::SUM_W] ? '1 : s[rcs_pkg::SUM_W-1:0];
	endfunction

	assign col_end = END_W'(cfg.roi_left) + END_W'(cfg.roi_width);
	assign row_end = END_W'(cfg.roi_top) + END_W'(cfg.roi_height);

	// The rectangle bounds are compared without wrap and clipped to the frame.
	assign in_roi = (pix.col >= cfg.roi_left) && (END_W'(pix.col) < col_end) &&
		(pix.row >= cfg.roi_top) && (END_W'(pix.row) < row_end) &&
		(int'(pix.col) < rcs_pkg::MAX_COLS) && (int'(pix.row) < rcs_pkg::MAX_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= stats_clr();
		end else begin
			priority if (clear) begin
				stats_q <= stats_clr();
			end else if (acc_en) begin
				if (in_roi) begin
					if (pix.pixel_l < stats_q.min_l) stats_q.min_l <= pix.pixel_l;
					if (pix.pixel_l > stats_q.max_l) stats_q.max_l <= pix.pixel_l;
					if (pix.pixel_a < stats_q.min_a) stats_q.min_a <= pix.pixel_a;
					if (pix.pixel_a > stats_q.max_a) stats_q.max_a <= pix.pixel_a;
					if (pix.pixel_l > cfg.thresh_l) stats_q.above_l <= cnt_inc(stats_q.above_l);
					if (pix.pixel_a > cfg.thresh_a) stats_q.above_a <= cnt_inc(stats_q.above_a);
					stats_q.roi_cnt   <= cnt_inc(stats_q.roi_cnt);
					stats_q.roi_sum_l <= sum_add(stats_q.roi_sum_l, pix.pixel_l);
					stats_q.roi_sum_a <= sum_add(stats_q.roi_sum_a, pix.pixel_a);
				end
				stats_q.frame_cnt   <= cnt_inc(stats_q.frame_cnt);
				stats_q.frame_sum_l <= sum_add(stats_q.frame_sum_l, pix.pixel_l);
				stats_q.frame_sum_a <= sum_add(stats_q.frame_sum_a, pix.pixel_a);
			end else begin
				stats_q <= stats_q;
			end
		end
	end

	assign stats = stats_q;

endmodule

// ===== sv/rcs_divider.sv =====
module rcs_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcs_pkg::rcs_div_req_t req,
	output rcs_pkg::rcs_div_rsp_t rsp
);

	localparam int DW    = rcs_pkg::DIVIDEND_W;
	localparam int VW    = rcs_pkg::CNT_W;
	localparam int CW    = $clog2(DW);
	localparam int LAST  = DW - 1;

	// Restoring division, one quotient bit a cycle. The dividend shifts out of
	// the top of quo_q while quotient bits shift in at the bottom.
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(rem_sh - {1'b0, den_q}) : rem_sh[VW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== sv/rcs_checker.sv =====
module rcs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input rcs_pkg::rcs_in_t  pix,
	input logic              res_valid,
	input logic              res_stall,
	input rcs_pkg::rcs_out_t res
);

	// A stalled result item holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// The end of a frame starts the divisions, so the input stalls right after it.
	a_eof_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && pix.end_of_frame |=> pix_stall)
		else $error("input not stalled after end of frame");

	// An empty rectangle reports zero for all of its features.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.roi_empty |-> res.roi_max_l == '0 && res.roi_min_l == '0 &&
		res.roi_max_a == '0 && res.roi_min_a == '0 && res.roi_pct_l == '0 &&
		res.roi_pct_a == '0 && res.roi_mean_l == '0 && res.roi_mean_a == '0)
		else $error("empty rectangle with nonzero features");

	// A rectangle with pixels has its minimum no larger than its maximum.
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.roi_empty |->
		res.roi_min_l <= res.roi_max_l && res.roi_min_a <= res.roi_max_a)
		else $error("minimum above maximum");

	// Percentages and means stay within their clamp limits.
	a_limits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 16'(res.roi_pct_l) <= rcs_pkg::PCT_MAX &&
		16'(res.roi_pct_a) <= rcs_pkg::PCT_MAX &&
		res.roi_mean_l <= rcs_pkg::MEAN_MAX && res.roi_mean_a <= rcs_pkg::MEAN_MAX &&
		res.frame_mean_l <= rcs_pkg::MEAN_MAX && res.frame_mean_a <= rcs_pkg::MEAN_MAX)
		else $error("feature beyond its limit");

endmodule

bind roi_color_statistics_unit rcs_checker u_rcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pix       (pix),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== test/tb_roi_color_statistics_unit.sv =====
module tb_roi_color_statistics_unit;

	// The watchdog ends the run when neither side moves an item for this many cycles.
	// The slowest legal stretch is the long output hold below, plus one frame close.
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int LONG_HOLD_CYCLES = 800;
	// A plain pixel is folded into the registered statistics, so a short settle is enough
	// before a register write once all expected results are in.
	localparam int DRAIN_SETTLE     = 4;
	// Settle at the end for longer than a frame close takes.
	localparam int END_SETTLE       = 300;
	localparam int MEAN_SCALE       = 256;
	localparam int SIZE_FULL        = 4095;
	localparam int RANDOM_PIXELS    = 380;
	localparam logic [rcs_pkg::CNT_W-1:0] CNT_FULL = '1;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           pix_valid = 1'b0;
	logic                           pix_stall;
	rcs_pkg::rcs_in_t               pix       = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	rcs_pkg::rcs_out_t              res;
	logic                           cfg_we    = 1'b0;
	logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rcs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// Window and thresholds as the block should currently hold them.
	logic [rcs_pkg::COORD_W-1:0] win_left;
	logic [rcs_pkg::COORD_W-1:0] win_top;
	logic [rcs_pkg::SIZE_W-1:0]  win_width;
	logic [rcs_pkg::SIZE_W-1:0]  win_height;
	logic [rcs_pkg::PIX_W-1:0]   lim_l;
	logic [rcs_pkg::PIX_W-1:0]   lim_a;

	// Running statistics of the frame in progress and the frame results still owed.
	rcs_pkg::rcs_stats_t acc;
	rcs_pkg::rcs_out_t   pending_stats[$];

	bit src_idle_en   = 1'b1;
	bit sink_idle_en  = 1'b1;
	bit long_hold_req = 1'b0;

	int unsigned fail_count      = 0;
	int unsigned pixels_sent     = 0;
	int unsigned frames_closed   = 0;
	int unsigned results_seen    = 0;
	int unsigned windows_applied = 0;
	int unsigned long_holds      = 0;
	int unsigned quiet_cycles    = 0;

	roi_color_statistics_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Statistics predictor
	// ------------------------------------------------------------------

	function automatic void clear_acc();
		acc = '0;
		acc.min_l = '1;
		acc.min_a = '1;
	endfunction

	// Counts and sums stick at their full-scale value instead of wrapping.
	function automatic logic [rcs_pkg::CNT_W-1:0] count_up(logic [rcs_pkg::CNT_W-1:0] c);
		return (c == CNT_FULL) ? c : c + 1'b1;
	endfunction

	function automatic logic [rcs_pkg::SUM_W-1:0] sum_up(logic [rcs_pkg::SUM_W-1:0] s,
		logic [rcs_pkg::PIX_W-1:0] v);
		logic [rcs_pkg::SUM_W:0] t;
		t = {1'b0, s} + v;
		return t[rcs_pkg::SUM_W] ? {rcs_pkg::SUM_W{1'b1}} : t[rcs_pkg::SUM_W-1:0];
	endfunction

	// Truncating fixed-point ratio, clamped; a zero count gives zero.
	function automatic longint unsigned ratio_q(longint unsigned num, longint unsigned scale,
		longint unsigned den, longint unsigned lim);
		longint unsigned q;
		if (den == 0)
			return 0;
		q = num * scale / den;
		return (q > lim) ? lim : q;
	endfunction

	// Folds one accepted pixel into the predicted statistics. On the end-of-frame
	// pixel the frame result is queued and the statistics start over.
	function automatic void fold_pixel(rcs_pkg::rcs_in_t p);
		int unsigned       cx;
		int unsigned       ry;
		bit                in_window;
		rcs_pkg::rcs_out_t r;
		cx = p.col;
		ry = p.row;
		// The window edges are compared without wrap, and the window is clipped
		// to the frame size.
		in_window = cx >= win_left && cx < 32'(win_left) + 32'(win_width) &&
			ry >= win_top && ry < 32'(win_top) + 32'(win_height) &&
			cx < rcs_pkg::MAX_COLS && ry < rcs_pkg::MAX_ROWS;
		if (in_window) begin
			if (p.pixel_l < acc.min_l)
				acc.min_l = p.pixel_l;
			if (p.pixel_l > acc.max_l)
				acc.max_l = p.pixel_l;
			if (p.pixel_a < acc.min_a)
				acc.min_a = p.pixel_a;
			if (p.pixel_a > acc.max_a)
				acc.max_a = p.pixel_a;
			if (p.pixel_l > lim_l)
				acc.above_l = count_up(acc.above_l);
			if (p.pixel_a > lim_a)
				acc.above_a = count_up(acc.above_a);
			acc.roi_cnt   = count_up(acc.roi_cnt);
			acc.roi_sum_l = sum_up(acc.roi_sum_l, p.pixel_l);
			acc.roi_sum_a = sum_up(acc.roi_sum_a, p.pixel_a);
		end
		acc.frame_cnt   = count_up(acc.frame_cnt);
		acc.frame_sum_l = sum_up(acc.frame_sum_l, p.pixel_l);
		acc.frame_sum_a = sum_up(acc.frame_sum_a, p.pixel_a);
		if (!p.end_of_frame)
			return;
		r = '0;
		if (acc.roi_cnt != 0) begin
			r.roi_max_l  = acc.max_l;
			r.roi_min_l  = acc.min_l;
			r.roi_pct_l  = rcs_pkg::PCT_W'(ratio_q(acc.above_l, rcs_pkg::PCT_SCALE,
				acc.roi_cnt, rcs_pkg::PCT_MAX));
			r.roi_max_a  = acc.max_a;
			r.roi_min_a  = acc.min_a;
			r.roi_pct_a  = rcs_pkg::PCT_W'(ratio_q(acc.above_a, rcs_pkg::PCT_SCALE,
				acc.roi_cnt, rcs_pkg::PCT_MAX));
			r.roi_mean_l = rcs_pkg::MEAN_W'(ratio_q(acc.roi_sum_l, MEAN_SCALE,
				acc.roi_cnt, rcs_pkg::MEAN_MAX));
			r.roi_mean_a = rcs_pkg::MEAN_W'(ratio_q(acc.roi_sum_a, MEAN_SCALE,
				acc.roi_cnt, rcs_pkg::MEAN_MAX));
		end else begin
			// Nothing fell inside the window: only the frame means survive.
			r.roi_empty = 1'b1;
		end
		r.frame_mean_l = rcs_pkg::MEAN_W'(ratio_q(acc.frame_sum_l, MEAN_SCALE,
			acc.frame_cnt, rcs_pkg::MEAN_MAX));
		r.frame_mean_a = rcs_pkg::MEAN_W'(ratio_q(acc.frame_sum_a, MEAN_SCALE,
			acc.frame_cnt, rcs_pkg::MEAN_MAX));
		pending_stats = {pending_stats, r};
		frames_closed++;
		clear_acc();
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void check_field(string name, logic [rcs_pkg::MEAN_W-1:0] want,
		logic [rcs_pkg::MEAN_W-1:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			fail_count++;
		end
	endfunction

	// Every result item taken by the receiver is compared with the oldest frame
	// result still owed. Inputs are driven by nonblocking assignments, so the
	// values seen here are the ones the block saw at this edge.
	always @(posedge clk) begin : result_check
		rcs_pkg::rcs_out_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			results_seen++;
			if (pending_stats.size() == 0) begin
				$error("result item arrived while no frame result was owed");
				fail_count++;
			end else begin
				want = pending_stats.pop_front();
				check_field("roi_max_l", want.roi_max_l, res.roi_max_l);
				check_field("roi_min_l", want.roi_min_l, res.roi_min_l);
				check_field("roi_pct_l", want.roi_pct_l, res.roi_pct_l);
				check_field("roi_max_a", want.roi_max_a, res.roi_max_a);
				check_field("roi_min_a", want.roi_min_a, res.roi_min_a);
				check_field("roi_pct_a", want.roi_pct_a, res.roi_pct_a);
				check_field("roi_mean_l", want.roi_mean_l, res.roi_mean_l);
				check_field("roi_mean_a", want.roi_mean_a, res.roi_mean_a);
				check_field("frame_mean_l", want.frame_mean_l, res.frame_mean_l);
				check_field("frame_mean_a", want.frame_mean_a, res.frame_mean_a);
				check_field("roi_empty", want.roi_empty, res.roi_empty);
			end
		end
	end

	// Watchdog: any accepted item on either side restarts the count.
	always @(posedge clk) begin
		if ((pix_valid && pix_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stall bursts, sometimes followed by a stall-free stretch,
	// plus the long hold-off that a test can ask for. The hold-off is counted
	// here, in the receiver's own process.
	initial begin : receiver
		int hold_left;
		int calm_left;
		hold_left = 0;
		calm_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_holds++;
				hold_left = LONG_HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				res_stall <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 99) < 7) begin
				hold_left = $urandom_range(1, 18) - 1;
				calm_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 80) : 0;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	function automatic rcs_pkg::rcs_in_t make_pixel(int l, int a, int c, int r, bit eof);
		rcs_pkg::rcs_in_t p;
		p.pixel_l      = rcs_pkg::PIX_W'(l);
		p.pixel_a      = rcs_pkg::PIX_W'(a);
		p.col          = rcs_pkg::COORD_W'(c);
		p.row          = rcs_pkg::COORD_W'(r);
		p.end_of_frame = eof;
		return p;
	endfunction

	// Offers one pixel and returns at the edge where it is accepted. Valid stays
	// high afterwards so that the next pixel can follow back to back; whoever
	// stops sending lowers it.
	task automatic offer_pixel(input rcs_pkg::rcs_in_t p);
		int gap;
		if (src_idle_en && $urandom_range(0, 99) < 9) begin
			gap = $urandom_range(1, 18);
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		do
			@(posedge clk);
		while (pix_stall !== 1'b0);
		fold_pixel(p);
		pixels_sent++;
	endtask

	// Stops sending and waits until every owed frame result has come back, then
	// lets a plain pixel still in flight settle.
	task automatic wait_for_results();
		pix_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	// One register write; the write enable is left high for a following write.
	task automatic put_reg(input logic [rcs_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= rcs_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		case (idx)
			rcs_pkg::CFG_ROI_LEFT:   win_left   = rcs_pkg::COORD_W'(val);
			rcs_pkg::CFG_ROI_TOP:    win_top    = rcs_pkg::COORD_W'(val);
			rcs_pkg::CFG_ROI_WIDTH:  win_width  = rcs_pkg::SIZE_W'(val);
			rcs_pkg::CFG_ROI_HEIGHT: win_height = rcs_pkg::SIZE_W'(val);
			rcs_pkg::CFG_THRESH_L:   lim_l      = rcs_pkg::PIX_W'(val);
			rcs_pkg::CFG_THRESH_A:   lim_a      = rcs_pkg::PIX_W'(val);
			default: ;
		endcase
	endtask

	// Writes all six registers back to back. Only called with the block idle.
	task automatic apply_window(input int left, input int top, input int width,
		input int height, input int t_l, input int t_a);
		put_reg(rcs_pkg::CFG_ROI_LEFT, left);
		put_reg(rcs_pkg::CFG_ROI_TOP, top);
		put_reg(rcs_pkg::CFG_ROI_WIDTH, width);
		put_reg(rcs_pkg::CFG_ROI_HEIGHT, height);
		put_reg(rcs_pkg::CFG_THRESH_L, t_l);
		put_reg(rcs_pkg::CFG_THRESH_A, t_a);
		cfg_we <= 1'b0;
		windows_applied++;
	endtask

	// Pixel values lean toward the extremes and the neighborhood of the threshold,
	// since that is where the strict comparison matters.
	function automatic logic [rcs_pkg::PIX_W-1:0] pick_value(logic [rcs_pkg::PIX_W-1:0] lim);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return lim + rcs_pkg::PIX_W'($urandom_range(0, 2)) - 1'b1;
			default: return rcs_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// One phase: a small raster frame geometry, a window placed against it, and a
	// few frames streamed in raster order. With noise on, some pixels get random
	// coordinates, some frames lose their end mark (so statistics carry into the
	// next frame, possibly across a register change), and some close early.
	task automatic run_frames(input bit noisy, input int nframes);
		int               ox, oy, fw, fh, npix, early_at, k, f;
		int               left, top, w, h;
		bit               drop_eof;
		rcs_pkg::rcs_in_t p;
		fw = $urandom_range(1, 8);
		fh = $urandom_range(1, 5);
		case ($urandom_range(0, 9))
			6, 7: begin
				ox = rcs_pkg::MAX_COLS - fw;
				oy = rcs_pkg::MAX_ROWS - fh;
			end
			8, 9: begin
				ox = $urandom_range(0, rcs_pkg::MAX_COLS - fw);
				oy = $urandom_range(0, rcs_pkg::MAX_ROWS - fh);
			end
			default: begin
				ox = 0;
				oy = 0;
			end
		endcase
		case ($urandom_range(0, 11))
			0: begin
				left = 0;
				top  = 0;
				w    = rcs_pkg::MAX_COLS;
				h    = rcs_pkg::MAX_ROWS;
			end
			1: begin
				left = ox + fw - 1;
				top  = oy + fh - 1;
				w    = $urandom_range(1, 3);
				h    = $urandom_range(1, 3);
			end
			2: begin
				// Zero width or zero height: the window holds nothing.
				left = ox;
				top  = oy;
				w    = $urandom_range(0, 1) ? 0 : fw;
				h    = (w == 0) ? fh : 0;
			end
			3: begin
				left = ox + $urandom_range(0, fw - 1);
				top  = oy + $urandom_range(0, fh - 1);
				w    = SIZE_FULL;
				h    = SIZE_FULL;
			end
			4: begin
				left = rcs_pkg::MAX_COLS - 1;
				top  = rcs_pkg::MAX_ROWS - 1;
				w    = $urandom_range(1, SIZE_FULL);
				h    = $urandom_range(1, SIZE_FULL);
			end
			default: begin
				left = ox + $urandom_range(0, fw - 1);
				top  = oy + $urandom_range(0, fh - 1);
				w    = $urandom_range(1, fw);
				h    = $urandom_range(1, fh);
			end
		endcase
		wait_for_results();
		apply_window(left, top, w, h, pick_limit(), pick_limit());
		npix = fw * fh;
		for (f = 0; f < nframes; f++) begin
			drop_eof = noisy && $urandom_range(0, 99) < 6;
			early_at = (noisy && $urandom_range(0, 99) < 5) ? $urandom_range(0, npix - 1) : -1;
			for (k = 0; k < npix; k++) begin
				p.pixel_l = pick_value(lim_l);
				p.pixel_a = pick_value(lim_a);
				if (noisy && $urandom_range(0, 99) < 7) begin
					p.col = rcs_pkg::COORD_W'($urandom_range(0, rcs_pkg::MAX_COLS - 1));
					p.row = rcs_pkg::COORD_W'($urandom_range(0, rcs_pkg::MAX_ROWS - 1));
				end else begin
					p.col = rcs_pkg::COORD_W'(ox + k % fw);
					p.row = rcs_pkg::COORD_W'(oy + k / fw);
				end
				p.end_of_frame = (k == npix - 1 && !drop_eof) || k == early_at;
				offer_pixel(p);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, the strict threshold compare, window clipping at the frame
	// edge, an empty window, an oversized window, and a register change in the
	// middle of a frame.
	task automatic test_directed();
		// Reset window is the single pixel at the origin.
		offer_pixel(make_pixel(255, 0, 0, 0, 1'b1));
		offer_pixel(make_pixel(0, 255, rcs_pkg::MAX_COLS - 1, rcs_pkg::MAX_ROWS - 1, 1'b1));
		// Values equal to the thresholds are not counted, one above is.
		offer_pixel(make_pixel(rcs_pkg::THRESH_L_RST, rcs_pkg::THRESH_A_RST, 0, 0, 1'b0));
		offer_pixel(make_pixel(rcs_pkg::THRESH_L_RST + 1, rcs_pkg::THRESH_A_RST + 1, 0, 0,
			1'b0));
		offer_pixel(make_pixel(0, 0, 5, 5, 1'b1));

		// Window runs past the frame edge and is clipped to it.
		wait_for_results();
		apply_window(rcs_pkg::MAX_COLS - 3, rcs_pkg::MAX_ROWS - 3, rcs_pkg::MAX_COLS,
			rcs_pkg::MAX_ROWS, 0, 255);
		offer_pixel(make_pixel(0, 1, rcs_pkg::MAX_COLS - 1, rcs_pkg::MAX_ROWS - 1, 1'b0));
		offer_pixel(make_pixel(255, 255, rcs_pkg::MAX_COLS - 2, rcs_pkg::MAX_ROWS - 3, 1'b0));
		offer_pixel(make_pixel(7, 9, rcs_pkg::MAX_COLS - 4, rcs_pkg::MAX_ROWS - 1, 1'b0));
		offer_pixel(make_pixel(1, 0, rcs_pkg::MAX_COLS - 3, rcs_pkg::MAX_ROWS - 4, 1'b1));

		// Zero width: nothing is inside even at the window's corner.
		wait_for_results();
		apply_window(0, 0, 0, 5, 100, 100);
		offer_pixel(make_pixel(200, 200, 0, 0, 1'b1));

		// Largest width and height the registers hold.
		wait_for_results();
		apply_window(3, 2, SIZE_FULL, SIZE_FULL, 0, 0);
		offer_pixel(make_pixel(0, 0, 3, 2, 1'b0));
		offer_pixel(make_pixel(255, 255, rcs_pkg::MAX_COLS - 1, rcs_pkg::MAX_ROWS - 1, 1'b1));

		// The window moves between two pixels of one frame; each pixel is judged
		// against the window in force when it arrives.
		wait_for_results();
		apply_window(0, 0, 2, 1, 255, 0);
		offer_pixel(make_pixel(10, 20, 0, 0, 1'b0));
		wait_for_results();
		apply_window(1, 0, 1, 1, 20, 30);
		offer_pixel(make_pixel(30, 40, 1, 0, 1'b1));
	endtask

	// The bulk of the run: mostly well-formed frames with noise mixed in.
	task automatic test_random_frames();
		int unsigned first_pixels;
		first_pixels = pixels_sent;
		while (pixels_sent - first_pixels < RANDOM_PIXELS)
			run_frames(1'b1, $urandom_range(2, 5));
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// pixels: one result sits in the output, the next frame close backs up, and
	// the block must stall its input.
	task automatic test_output_hold();
		int               k;
		rcs_pkg::rcs_in_t p;
		wait_for_results();
		apply_window(0, 0, rcs_pkg::MAX_COLS, rcs_pkg::MAX_ROWS, rcs_pkg::THRESH_L_RST,
			rcs_pkg::THRESH_A_RST);
		src_idle_en   = 1'b0;
		long_hold_req = 1'b1;
		for (k = 0; k < 16; k++) begin
			p = make_pixel($urandom_range(0, 255), $urandom_range(0, 255), k % 4, k / 4,
				k % 4 == 3);
			offer_pixel(p);
		end
		wait_for_results();
		src_idle_en = 1'b1;
	endtask

	// Last part: no idling on either side, clean frames back to back.
	task automatic test_streaming();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (2) run_frames(1'b0, $urandom_range(3, 6));
	endtask

	initial begin
		win_left   = '0;
		win_top    = '0;
		win_width  = rcs_pkg::SIZE_W'(1);
		win_height = rcs_pkg::SIZE_W'(1);
		lim_l      = rcs_pkg::THRESH_L_RST;
		lim_a      = rcs_pkg::THRESH_A_RST;
		clear_acc();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_output_hold();
		test_streaming();

		wait_for_results();
		repeat (END_SETTLE) @(posedge clk);

		$display("Sent %0d pixels closing %0d frames, checked %0d frame results under %0d window settings.",
			pixels_sent, frames_closed, results_seen, windows_applied);
		$display("Included %0d long output hold-off(s) and a stall-free closing stretch.",
			long_holds);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
